// ===== src/spc_pkg.sv =====
// shared types and constants of the stroke point conditioner
package spc_pkg;

    localparam int RAD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int FRAC_BITS = 8;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CFG_W-1:0] RATE_RESET = 16'd256;

    localparam logic REG_NOISE = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_M0   = 15'b000000000000010,
        S_M1   = 15'b000000000000100,
        S_M2   = 15'b000000000001000,
        S_M3   = 15'b000000000010000,
        S_M4   = 15'b000000000100000,
        S_A0   = 15'b000000001000000,
        S_A1   = 15'b000000010000000,
        S_A2   = 15'b000000100000000,
        S_A3   = 15'b000001000000000,
        S_SQ   = 15'b000010000000000,
        S_SQW  = 15'b000100000000000,
        S_R0   = 15'b001000000000000,
        S_R1   = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } t_state;

endpackage

// ===== src/stroke_point_conditioner.sv =====
// stroke point conditioner top level: sequencer, held points and config registers
// One point at a time: the input is ready only while the block is idle. A point that starts
// a stroke goes from acceptance straight to S_DONE. An appended point passes S_A0 to S_A3,
// S_SQ, S_SQW, S_R0 and S_R1; in S_SQW the bit-serial square root yields one root bit per
// cycle until it has all LEN_W root bits, LEN_W being COORD_WIDTH + 1 capped at 32. When
// merging is enabled and two points are held, the merge test on the shared multiplier runs
// first in S_M0 to S_M4, and a merged point goes from S_M4 straight to S_DONE.
// The block is ready again from the cycle in which its result is offered. The result sits
// in an output register, so a stalled result does not block acceptance of the next point,
// only its completion.
module stroke_point_conditioner #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // x_pos, y_pos, radius
    input  logic [((2*COORD_WIDTH+spc_pkg::RAD_W+7)/8)*8-1:0] i_s_axis_tdata,
    // new_stroke
    input  logic [0:0]                               i_s_axis_tuser,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // out_x, out_y, out_radius
    output logic [((2*COORD_WIDTH+spc_pkg::RAD_W+7)/8)*8-1:0] o_m_axis_tdata,
    // merged
    output logic [0:0]                               o_m_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [spc_pkg::PADDR_W-1:0]              paddr,
    input  logic [spc_pkg::APB_W-1:0]                pwdata,
    output logic [spc_pkg::APB_W-1:0]                prdata,
    output logic                                     pready
);
    import spc_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int LEN_W   = (CW < 32) ? CW + 1 : 32;
    localparam int MUL_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 2 * CW;
    localparam int SUM_W   = SQ_W + 1;
    localparam int DS_W    = (SUM_W > 64) ? 64 : SUM_W;
    localparam int CMP_W   = (DS_W > 2*CFG_W) ? DS_W : 2*CFG_W;
    localparam int LIM_W   = RAD_W + LEN_W - FRAC_BITS;
    localparam int DATA_W  = 2*CW + RAD_W;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0] r_thr;
    logic [CFG_W-1:0] r_rate;

    logic signed [CW-1:0] r_in_x, r_in_y, r_old_x, r_old_y, r_new_x, r_new_y;
    logic [RAD_W-1:0]     r_in_r, r_new_r, r_res_r;
    logic [1:0]           r_cnt;
    logic                 r_merged;
    logic [SUM_W-1:0]     r_acc;

    logic signed [CW-1:0] r_out_x, r_out_y;
    logic [RAD_W-1:0]     r_out_r;
    logic                 r_out_merged;
    logic                 r_out_valid;

    logic                 in_acc, cfg_wr, out_free;
    logic [1:0]           cnt_eff;
    logic signed [CW:0]   diff;
    logic [CW-1:0]        adiff;
    logic signed [CW-1:0] dsel_a, dsel_b;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    prod;
    logic                 sat;
    logic [DS_W-1:0]      dist_sq;
    logic                 near;
    logic [LIM_W-1:0]     lim;
    logic [LIM_W:0]       lim_sum;
    logic [RAD_W-1:0]     lim_r;
    logic [RAD_W-1:0]     rdiff;
    logic                 sq_start;
    logic                 sq_done;
    logic [LEN_W-1:0]     root;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign cnt_eff  = i_s_axis_tuser[0] ? 2'd0 : r_cnt;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_rate <= RATE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_RATE) begin
                r_rate <= pwdata[CFG_W-1:0];
            end else begin
                r_thr <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NOISE) ? APB_W'(r_thr) : APB_W'(r_rate);

    // distance operand selection
    always_comb begin
        dsel_a = r_in_x;
        dsel_b = r_new_x;
        case (r_state)
            S_M0: begin
                dsel_a = r_in_x;
                dsel_b = r_old_x;
            end
            S_M1: begin
                dsel_a = r_in_y;
                dsel_b = r_old_y;
            end
            S_A1: begin
                dsel_a = r_in_y;
                dsel_b = r_new_y;
            end
            default: begin
                dsel_a = r_in_x;
                dsel_b = r_new_x;
            end
        endcase
    end

    assign diff  = {dsel_a[CW-1], dsel_a} - {dsel_b[CW-1], dsel_b};
    assign adiff = diff[CW] ? CW'(-diff) : diff[CW-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M0, S_M1, S_A0, S_A1: begin
                mul_a = MUL_W'(adiff);
                mul_b = MUL_W'(adiff);
            end
            S_M2: begin
                mul_a = MUL_W'(r_thr);
                mul_b = MUL_W'(r_thr);
            end
            S_SQW: begin
                mul_a = MUL_W'(r_rate);
                mul_b = MUL_W'(root);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    spc_mul #(.WIDTH(MUL_W)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign sat     = (SUM_W > DS_W) && r_acc[SUM_W-1];
    assign dist_sq = sat ? '1 : r_acc[DS_W-1:0];
    assign near    = CMP_W'(dist_sq) < CMP_W'(prod[2*CFG_W-1:0]);

    assign sq_start = (r_state == S_SQ);

    spc_isqrt #(.ROOT_W(LEN_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_op    ((2*LEN_W)'(dist_sq)),
        .o_done  (sq_done),
        .o_root  (root)
    );

    // radius rate limit
    always_comb begin
        lim     = prod[RAD_W+LEN_W-1:FRAC_BITS];
        lim_sum = (LIM_W+1)'(r_new_r) + (LIM_W+1)'(lim);
        lim_r   = r_in_r;
        rdiff   = '0;
        if (r_in_r > r_new_r) begin
            rdiff = r_in_r - r_new_r;
            if (LIM_W'(rdiff) > lim) begin
                lim_r = (lim_sum > (LIM_W+1)'({RAD_W{1'b1}})) ? '1 : lim_sum[RAD_W-1:0];
            end
        end else begin
            rdiff = r_new_r - r_in_r;
            if (LIM_W'(rdiff) > lim) begin
                lim_r = (lim >= LIM_W'(r_new_r)) ? '0 : r_new_r - lim[RAD_W-1:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_thr != '0 && cnt_eff == 2'd2) begin
                        n_state = S_M0;
                    end else if (cnt_eff != 2'd0) begin
                        n_state = S_A0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_M0:  n_state = S_M1;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_M4;
            S_M4:  n_state = near ? S_DONE : S_A0;
            S_A0:  n_state = S_A1;
            S_A1:  n_state = S_A2;
            S_A2:  n_state = S_A3;
            S_A3:  n_state = S_SQ;
            S_SQ:  n_state = S_SQW;
            S_SQW: n_state = sq_done ? S_R0 : S_SQW;
            S_R0:  n_state = S_R1;
            S_R1:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cnt <= cnt_eff;
            end else if (r_state == S_DONE && out_free && !r_merged) begin
                r_cnt <= (r_cnt == 2'd2) ? 2'd2 : r_cnt + 2'd1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath and held points
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_in_x   <= i_s_axis_tdata[CW-1:0];
                    r_in_y   <= i_s_axis_tdata[2*CW-1:CW];
                    r_in_r   <= i_s_axis_tdata[2*CW+RAD_W-1:2*CW];
                    r_res_r  <= i_s_axis_tdata[2*CW+RAD_W-1:2*CW];
                    r_merged <= 1'b0;
                end
            end
            S_M2, S_A2: r_acc <= SUM_W'(prod[SQ_W-1:0]);
            S_M3, S_A3: r_acc <= r_acc + SUM_W'(prod[SQ_W-1:0]);
            S_M4: begin
                if (near) begin
                    r_merged <= 1'b1;
                    r_res_r  <= (r_in_r > r_new_r) ? r_in_r : r_new_r;
                end
            end
            S_R1: r_res_r <= lim_r;
            S_DONE: begin
                if (out_free) begin
                    if (!r_merged) begin
                        r_old_x <= r_new_x;
                        r_old_y <= r_new_y;
                    end
                    r_new_x      <= r_in_x;
                    r_new_y      <= r_in_y;
                    r_new_r      <= r_res_r;
                    r_out_x      <= r_in_x;
                    r_out_y      <= r_in_y;
                    r_out_r      <= r_res_r;
                    r_out_merged <= r_merged;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_out_r, r_out_y, r_out_x});
    assign o_m_axis_tuser  = r_out_merged;
endmodule

// ===== src/spc_mul.sv =====
// shared unsigned multiplier with registered operands and product
module spc_mul #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic [2*WIDTH-1:0] o_p
);
    logic [WIDTH-1:0]   r_a;
    logic [WIDTH-1:0]   r_b;
    logic [2*WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_b <= i_b;
        r_p <= r_a * r_b;
    end

    assign o_p = r_p;
endmodule

// ===== src/spc_isqrt.sv =====
// bit-serial floor integer square root, one root bit per cycle
module spc_isqrt #(
    parameter int ROOT_W = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*ROOT_W-1:0] i_op,
    output logic                o_done,
    output logic [ROOT_W-1:0]   o_root
);
    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 3;

    logic [2*ROOT_W-1:0] r_op;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {r_rem[ROOT_W:0], r_op[2*ROOT_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_op;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op <= {r_op[2*ROOT_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== src/spc_checker.sv =====
// port-level checks of the stroke point conditioner and their binding
module spc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [spc_pkg::PADDR_W-1:0]  paddr,
    input logic [spc_pkg::APB_W-1:0]    pwdata,
    input logic [spc_pkg::APB_W-1:0]    prdata
);
    import spc_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // one point at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after an accepted beat");

    // a new result appears as the block goes idle
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result shown while still busy");

    // register readback
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr))
        |-> prdata == APB_W'($past(pwdata[CFG_W-1:0])))
        else $error("register readback mismatch");
endmodule

bind stroke_point_conditioner spc_checker u_spc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);
